// ===== design/rti_pkg.sv =====
// Shared types, widths and latencies for the ray/triangle intersection pipeline.
package rti_pkg;

  // coordinate and derived widths
  localparam int CW   = 32;            // coordinate width
  localparam int FB   = 16;            // fraction bits
  localparam int DW   = CW + 1;        // coordinate difference
  localparam int PW   = 2 * DW;        // product of two differences
  localparam int MW   = PW + 1;        // 2x2 minor
  localparam int LOW  = DW + 1;        // low slice of a minor fed to one multiplier
  localparam int TW   = MW + DW;       // minor times difference
  localparam int DETW = TW + 2;        // sum of three terms
  localparam int QB   = CW + 2;        // quotient bits kept by the divider
  localparam int RW   = DETW + QB;     // divider remainder width

  // pipeline latencies
  localparam int DET_LAT  = 5;
  localparam int DIV_LAT  = QB + 2;
  localparam int SIDE_LAT = DET_LAT + DIV_LAT;
  localparam int VLEN     = SIDE_LAT + 4;

  // configuration port
  localparam int CFG_AW = 4;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [DW-1:0]   diff_t;
  typedef logic signed [DETW-1:0] det_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [QB-1:0] ONE_Q = QB'(64'd1 << FB);

  typedef enum logic [1:0] {
    REG_EYE_X = 2'd0,
    REG_EYE_Y = 2'd1,
    REG_EYE_Z = 2'd2,
    REG_NEAR  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    logic   beyond_near;
    coord_t ray_param;
    coord_t hit_x;
    coord_t hit_y;
    coord_t hit_z;
  } out_result_t;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t near_distance;
  } cfg_regs_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } vec_t;

  typedef struct packed {
    logic          ovf;
    logic          neg;
    logic [QB-1:0] mag;
  } quo_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    vec_t   ba;
    vec_t   ca;
  } side_t;

endpackage

// ===== design/rti_cfg.sv =====
// Configuration register file behind the APB-style port.
module rti_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rti_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rti_pkg::cfg_regs_t         regs_o
);
  import rti_pkg::*;

  cfg_regs_t regs_r, regs_nxt;
  reg_idx_t  idx;
  logic      wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign regs_o = regs_r;

  // decode the write word
  always_comb begin
    regs_nxt = regs_r;
    if (wr) begin
      unique case (idx)
        REG_EYE_X: regs_nxt.eye_x         = pwdata;
        REG_EYE_Y: regs_nxt.eye_y         = pwdata;
        REG_EYE_Z: regs_nxt.eye_z         = pwdata;
        REG_NEAR:  regs_nxt.near_distance = pwdata;
        default:   regs_nxt = regs_r;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_EYE_X: prdata = regs_r.eye_x;
      REG_EYE_Y: prdata = regs_r.eye_y;
      REG_EYE_Z: prdata = regs_r.eye_z;
      REG_NEAR:  prdata = regs_r.near_distance;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== design/rti_det.sv =====
// Pipelined exact 3x3 determinant v x u . w of coordinate differences.
module rti_det (
  input  logic          clk,
  input  rti_pkg::vec_t u_i,
  input  rti_pkg::vec_t v_i,
  input  rti_pkg::vec_t w_i,
  output rti_pkg::det_t det_o
);
  import rti_pkg::*;

  localparam int LOPW = LOW + 1 + DW;
  localparam int HIPW = MW - LOW + DW;

  logic signed [PW-1:0]   prod_r [6];
  logic signed [MW-1:0]   minor_r [3];
  logic signed [LOPW-1:0] lo_r [3];
  logic signed [HIPW-1:0] hi_r [3];
  logic signed [TW-1:0]   term_r [3];
  vec_t                   wa_r, wb_r;
  det_t                   det_r;
  diff_t                  wsel [3];

  assign wsel[0] = wb_r.x;
  assign wsel[1] = wb_r.y;
  assign wsel[2] = wb_r.z;

  // products of the 2x2 minors
  always_ff @(posedge clk) begin
    prod_r[0] <= PW'(u_i.z) * PW'(v_i.y);
    prod_r[1] <= PW'(u_i.y) * PW'(v_i.z);
    prod_r[2] <= PW'(u_i.z) * PW'(v_i.x);
    prod_r[3] <= PW'(u_i.x) * PW'(v_i.z);
    prod_r[4] <= PW'(u_i.y) * PW'(v_i.x);
    prod_r[5] <= PW'(u_i.x) * PW'(v_i.y);
    wa_r      <= w_i;
  end

  // minors
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      minor_r[k] <= MW'(prod_r[2*k]) - MW'(prod_r[2*k+1]);
    end
    wb_r <= wa_r;
  end

  // split each minor into two multiplies against w
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      lo_r[k] <= LOPW'($signed({1'b0, minor_r[k][LOW-1:0]})) * LOPW'(wsel[k]);
      hi_r[k] <= HIPW'($signed(minor_r[k][MW-1:LOW])) * HIPW'(wsel[k]);
    end
  end

  // recombine the halves
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      term_r[k] <= (TW'(hi_r[k]) <<< LOW) + TW'(lo_r[k]);
    end
  end

  // cofactor sum
  always_ff @(posedge clk) begin
    det_r <= DETW'(term_r[0]) - DETW'(term_r[1]) + DETW'(term_r[2]);
  end

  assign det_o = det_r;

endmodule

// ===== design/rti_div.sv =====
// Pipelined restoring divider: (num << FB) / den, truncated, one quotient bit per stage.
module rti_div (
  input  logic          clk,
  input  rti_pkg::det_t num_i,
  input  rti_pkg::det_t den_i,
  output rti_pkg::quo_t quo_o
);
  import rti_pkg::*;

  logic [DETW-1:0] nmag_r, dmag_r;
  logic            sg0_r;
  logic [RW-1:0]   rem_r [QB];
  logic [DETW-1:0] dv_r [QB];
  logic [QB-1:0]   q_r [QB+1];
  logic            sg_r [QB+1];
  logic            ov_r [QB+1];
  logic [RW-1:0]   rem0, dsh;

  // take magnitudes and the quotient sign
  always_ff @(posedge clk) begin
    nmag_r <= num_i[DETW-1] ? DETW'(-num_i) : DETW'(num_i);
    dmag_r <= den_i[DETW-1] ? DETW'(-den_i) : DETW'(den_i);
    sg0_r  <= num_i[DETW-1] ^ den_i[DETW-1];
  end

  // scale the numerator and flag quotients beyond the kept bits
  assign rem0 = RW'({nmag_r, {FB{1'b0}}});
  assign dsh  = {dmag_r, {QB{1'b0}}};

  always_ff @(posedge clk) begin
    rem_r[0] <= rem0;
    dv_r[0]  <= dmag_r;
    q_r[0]   <= '0;
    sg_r[0]  <= sg0_r;
    ov_r[0]  <= rem0 >= dsh;
  end

  // one trial subtract per stage, most significant bit first
  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int SH = QB - 1 - i;
    logic [RW-1:0] shd;
    logic          ge;

    assign shd = RW'(dv_r[i]) << SH;
    assign ge  = rem_r[i] >= shd;

    always_ff @(posedge clk) begin
      q_r[i+1]  <= q_r[i] | (QB'(ge) << SH);
      sg_r[i+1] <= sg_r[i];
      ov_r[i+1] <= ov_r[i];
    end

    if (i < QB - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[i+1] <= ge ? rem_r[i] - shd : rem_r[i];
        dv_r[i+1]  <= dv_r[i];
      end
    end
  end

  assign quo_o.ovf = ov_r[QB];
  assign quo_o.neg = sg_r[QB] & (ov_r[QB] | (|q_r[QB]));
  assign quo_o.mag = q_r[QB];

endmodule

// ===== design/ray_triangle_intersect.sv =====
// Top level: ray/triangle intersection by Cramer's rule, fully pipelined.
// Path of a word: input reg, differences, determinants, dividers, scaling, result reg.
// Throughput: one word per cycle; busy is held low and start is always taken.
// Depth: restoring dividers with 34 subtract stages after 5-stage determinant units.
// Reset clears the valid bits and the configuration registers; results cannot be stalled.
module ray_triangle_intersect (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  rti_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output rti_pkg::out_result_t       out_result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rti_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rti_pkg::*;

  localparam int SPW = FB + 2 + DW;
  localparam int SRW = SPW - FB;
  localparam int HW  = SRW + 2;

  cfg_regs_t   cfg;
  logic [VLEN-1:0] vld_r;
  in_item_t    in_r;
  vec_t        d_r, p_r, q_r, r_r;
  side_t       side_r [SIDE_LAT+1];
  det_t        den, nb, ng, nt;
  logic [DIV_LAT-1:0] zero_r;
  quo_t        qb, qg, qt;
  side_t       sd;

  logic        b_ok, g_ok, s_ok, hit1;
  logic [QB:0] bg_sum;
  logic        hit1_r, tbig_r;
  logic [CW-2:0] tlo_r;
  coord_t      a1_r [3];
  logic signed [SPW-1:0] pb_r [3], pg_r [3];
  out_result_t res_r, res_nxt;
  coord_t      hv [3];

  function automatic logic signed [SRW-1:0] trunc_q(input logic signed [SPW-1:0] p);
    logic signed [SPW-1:0] adj;
    adj = p + $signed({{(SPW-FB){1'b0}}, {FB{p[SPW-1]}}});
    return adj[SPW-1:FB];
  endfunction

  function automatic coord_t sat_c(input logic signed [HW-1:0] h);
    logic signed [HW-1:0] hi, lo;
    hi = HW'(CMAX);
    lo = HW'(CMIN);
    if (h > hi) return CMAX;
    else if (h < lo) return CMIN;
    else return h[CW-1:0];
  endfunction

  rti_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .regs_o (cfg)
  );

  assign busy = 1'b0;

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VLEN-2:0], start & ~busy};
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    in_r <= in_item;
  end

  // edge vectors and ray offset
  always_ff @(posedge clk) begin
    d_r.x <= DW'(in_r.dir_x);
    d_r.y <= DW'(in_r.dir_y);
    d_r.z <= DW'(in_r.dir_z);
    p_r.x <= DW'(in_r.a_x) - DW'(in_r.b_x);
    p_r.y <= DW'(in_r.a_y) - DW'(in_r.b_y);
    p_r.z <= DW'(in_r.a_z) - DW'(in_r.b_z);
    q_r.x <= DW'(in_r.a_x) - DW'(in_r.c_x);
    q_r.y <= DW'(in_r.a_y) - DW'(in_r.c_y);
    q_r.z <= DW'(in_r.a_z) - DW'(in_r.c_z);
    r_r.x <= DW'(in_r.a_x) - DW'(cfg.eye_x);
    r_r.y <= DW'(in_r.a_y) - DW'(cfg.eye_y);
    r_r.z <= DW'(in_r.a_z) - DW'(cfg.eye_z);
    side_r[0].ax   <= in_r.a_x;
    side_r[0].ay   <= in_r.a_y;
    side_r[0].az   <= in_r.a_z;
    side_r[0].ba.x <= DW'(in_r.b_x) - DW'(in_r.a_x);
    side_r[0].ba.y <= DW'(in_r.b_y) - DW'(in_r.a_y);
    side_r[0].ba.z <= DW'(in_r.b_z) - DW'(in_r.a_z);
    side_r[0].ca.x <= DW'(in_r.c_x) - DW'(in_r.a_x);
    side_r[0].ca.y <= DW'(in_r.c_y) - DW'(in_r.a_y);
    side_r[0].ca.z <= DW'(in_r.c_z) - DW'(in_r.a_z);
  end

  // carry the vertex data alongside the arithmetic
  always_ff @(posedge clk) begin
    for (int j = 1; j <= SIDE_LAT; j++) begin
      side_r[j] <= side_r[j-1];
    end
  end

  // four determinants of Cramer's rule
  rti_det u_det_den (.clk, .u_i(q_r), .v_i(d_r), .w_i(p_r), .det_o(den));
  rti_det u_det_b   (.clk, .u_i(q_r), .v_i(d_r), .w_i(r_r), .det_o(nb));
  rti_det u_det_g   (.clk, .u_i(r_r), .v_i(d_r), .w_i(p_r), .det_o(ng));
  rti_det u_det_t   (.clk, .u_i(q_r), .v_i(r_r), .w_i(p_r), .det_o(nt));

  // delay the singular-system flag to the divider outputs
  always_ff @(posedge clk) begin
    zero_r <= {zero_r[DIV_LAT-2:0], den == '0};
  end

  rti_div u_div_b (.clk, .num_i(nb), .den_i(den), .quo_o(qb));
  rti_div u_div_g (.clk, .num_i(ng), .den_i(den), .quo_o(qg));
  rti_div u_div_t (.clk, .num_i(nt), .den_i(den), .quo_o(qt));

  assign sd = side_r[SIDE_LAT];

  // range checks on beta, gamma and t
  assign b_ok   = !qb.ovf && !qb.neg && (qb.mag <= ONE_Q);
  assign g_ok   = !qg.ovf && !qg.neg && (qg.mag <= ONE_Q);
  assign bg_sum = (QB+1)'(qb.mag) + (QB+1)'(qg.mag);
  assign s_ok   = bg_sum <= (QB+1)'(ONE_Q);
  assign hit1   = !zero_r[DIV_LAT-1] && b_ok && g_ok && s_ok && !qt.neg;

  // scale the edges by beta and gamma
  always_ff @(posedge clk) begin
    hit1_r  <= hit1;
    tbig_r  <= qt.ovf | (|qt.mag[QB-1:CW-1]);
    tlo_r   <= qt.mag[CW-2:0];
    a1_r[0] <= sd.ax;
    a1_r[1] <= sd.ay;
    a1_r[2] <= sd.az;
    pb_r[0] <= SPW'($signed({1'b0, qb.mag[FB:0]})) * SPW'(sd.ba.x);
    pb_r[1] <= SPW'($signed({1'b0, qb.mag[FB:0]})) * SPW'(sd.ba.y);
    pb_r[2] <= SPW'($signed({1'b0, qb.mag[FB:0]})) * SPW'(sd.ba.z);
    pg_r[0] <= SPW'($signed({1'b0, qg.mag[FB:0]})) * SPW'(sd.ca.x);
    pg_r[1] <= SPW'($signed({1'b0, qg.mag[FB:0]})) * SPW'(sd.ca.y);
    pg_r[2] <= SPW'($signed({1'b0, qg.mag[FB:0]})) * SPW'(sd.ca.z);
  end

  // hit point sums, saturated
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hv[k] = sat_c(HW'(a1_r[k]) + HW'(trunc_q(pb_r[k])) + HW'(trunc_q(pg_r[k])));
    end
  end

  // assemble the result word, zero on a miss
  always_comb begin
    res_nxt = '0;
    if (hit1_r) begin
      res_nxt.hit         = 1'b1;
      res_nxt.beyond_near = tbig_r | ($signed({1'b0, tlo_r}) > cfg.near_distance);
      res_nxt.ray_param   = tbig_r ? CMAX : {1'b0, tlo_r};
      res_nxt.hit_x       = hv[0];
      res_nxt.hit_y       = hv[1];
      res_nxt.hit_z       = hv[2];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = vld_r[VLEN-1];
  assign out_result = res_r;

`ifndef ASSERT_OFF
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##VLEN out_valid)
    else $error("accepted word did not produce a result on time");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, VLEN))
    else $error("result strobe without an accepted word");

  a_beyond_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.beyond_near) |-> out_result.hit)
    else $error("beyond_near set on a miss");

  a_t_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.hit) |-> !out_result.ray_param[CW-1])
    else $error("negative ray parameter reported as hit");
`endif

endmodule
